@@ hw/rtl/bsad_pkg.sv @@
// Shared types, codes and lookup functions for the bank-switch address decoder.
`timescale 1ns / 1ps

package bsad_pkg;

  // Device codes carried on the result beat.
  typedef enum logic [2:0] {
    DEV_NONE    = 3'd0,
    DEV_RAM     = 3'd1,
    DEV_KERNAL  = 3'd2,
    DEV_BASIC   = 3'd3,
    DEV_CART_LO = 3'd4,
    DEV_CART_HI = 3'd5,
    DEV_IO      = 3'd6,
    DEV_CHAR    = 3'd7
  } dev_t;

  // Memory map regions, each made of one or more 4 KiB blocks.
  typedef enum logic [2:0] {
    REG_LO     = 3'd0,
    REG_MID    = 3'd1,
    REG_LOCART = 3'd2,
    REG_BASIC  = 3'd3,
    REG_HIRAM  = 3'd4,
    REG_IO     = 3'd5,
    REG_KERNAL = 3'd6
  } region_t;

  // I/O unit codes.
  localparam logic [2:0] IO_VIDEO = 3'd0;
  localparam logic [2:0] IO_SOUND = 3'd1;
  localparam logic [2:0] IO_COLOR = 3'd2;
  localparam logic [2:0] IO_CIA1  = 3'd3;
  localparam logic [2:0] IO_CIA2  = 3'd4;
  localparam logic [2:0] IO_IO1   = 3'd5;
  localparam logic [2:0] IO_IO2   = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_ROM_LINE  = 1'b0;
  localparam logic CFG_GAME_LINE = 1'b1;

  // Processor port addresses and reset values.
  localparam logic [15:0] PORT_DIR_ADDR  = 16'h0000;
  localparam logic [15:0] PORT_DATA_ADDR = 16'h0001;
  localparam logic [7:0]  PORT_DIR_RESET  = 8'h00;
  localparam logic [7:0]  PORT_DATA_RESET = 8'h37;

  // Banking bits taken from the port data byte.
  typedef struct packed {
    logic chr;
    logic hi;
    logic lo;
  } bank_bits_t;

  // One decoded result beat.
  typedef struct packed {
    logic [7:0]  device_data;
    logic        is_write;
    logic [7:0]  read_data;
    logic        port_hit;
    logic [2:0]  io_unit;
    logic [15:0] device_address;
    dev_t        device_select;
  } result_t;

  // Region of a 4 KiB block number.
  function automatic region_t region_of(input logic [3:0] blk);
    region_t r;
    case (blk)
      4'h0:                                     r = REG_LO;
      4'h8, 4'h9:                               r = REG_LOCART;
      4'hA, 4'hB:                               r = REG_BASIC;
      4'hC:                                     r = REG_HIRAM;
      4'hD:                                     r = REG_IO;
      4'hE, 4'hF:                               r = REG_KERNAL;
      default:                                  r = REG_MID;
    endcase
    return r;
  endfunction

  // Address mask that matches the size of each device.
  function automatic logic [15:0] mask_of(input dev_t dev);
    logic [15:0] m;
    unique case (dev)
      DEV_NONE:                                 m = 16'h0000;
      DEV_RAM:                                  m = 16'hFFFF;
      DEV_CART_HI, DEV_CHAR:                    m = 16'h0FFF;
      default:                                  m = 16'h1FFF;
    endcase
    return m;
  endfunction

  // I/O unit from the page number inside the I/O region.
  function automatic logic [2:0] io_unit_of(input logic [3:0] page);
    logic [2:0] u;
    case (page)
      4'h0, 4'h1, 4'h2, 4'h3:                   u = IO_VIDEO;
      4'h4, 4'h5, 4'h6, 4'h7:                   u = IO_SOUND;
      4'h8, 4'h9, 4'hA, 4'hB:                   u = IO_COLOR;
      4'hC:                                     u = IO_CIA1;
      4'hD:                                     u = IO_CIA2;
      4'hE:                                     u = IO_IO1;
      default:                                  u = IO_IO2;
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/bank_switch_address_decoder.sv @@
// Top level of the bank-switch address decoder: input stage, decode and result register.
//
// Usage:
//   The in_ channel carries one CPU bus access per beat: in_tuser is the access kind
//   (0 read, 1 write), in_tdata holds the address and the write byte. The out_ channel
//   returns one decoded beat per access, in order: selected device, address masked to
//   the device size, I/O unit, port read-back and the forwarded write byte.
//   The cfg_ port sets the cartridge expansion ROM and game lines; change them only
//   while no access is in flight.
//   An accepted beat is held in the input register and is then decoded into the result
//   register, where it raises out_tvalid. One beat is taken every cycle while out_tready
//   is high.
//   The processor port bytes update when a write beat leaves the input register, so
//   the next access always sees them.
//   Reset (rst_n low, synchronous) empties both stages, clears the cartridge lines and
//   sets the port to direction 0x00, data 0x37.
//   When the receiver holds out_tready low, the result beat waits in the output
//   register, the input register still takes one more beat, and in_tready then drops
//   until the output moves again.
`timescale 1ns / 1ps

module bank_switch_address_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] write_data
  input  logic        in_tuser,   // [0] command
  // Result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] device_select, [18:3] device_address, [21:19] io_unit,
  // [29:22] read_data, [37:30] device_data, [39:38] zero
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser,  // [0] port_hit, [1] is_write
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wr_data
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_cmd_r;
  logic [15:0]       s1_addr_r;
  logic [7:0]        s1_wdata_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  bsad_pkg::result_t out_res_r;
  bsad_pkg::result_t dec_res;
  logic              rom_line_r;
  logic              game_line_r;
  logic              out_free;
  logic              s1_adv;
  logic              in_fire;
  bsad_pkg::bank_bits_t bank;
  logic [7:0]        port_rd;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Cartridge line registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_line_r  <= 1'b0;
      game_line_r <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == bsad_pkg::CFG_ROM_LINE) begin
        rom_line_r <= cfg_wr_data;
      end
      if (cfg_index == bsad_pkg::CFG_GAME_LINE) begin
        game_line_r <= cfg_wr_data;
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_tuser;
      s1_addr_r  <= in_tdata[15:0];
      s1_wdata_r <= in_tdata[23:16];
    end
  end

  bsad_port u_port (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (s1_adv),
    .command    (s1_cmd_r),
    .address    (s1_addr_r),
    .write_data (s1_wdata_r),
    .bank       (bank),
    .read_data  (port_rd)
  );

  bsad_decode u_decode (
    .command      (s1_cmd_r),
    .address      (s1_addr_r),
    .write_data   (s1_wdata_r),
    .rom_line     (rom_line_r),
    .game_line    (game_line_r),
    .bank         (bank),
    .port_rd_data (port_rd),
    .result       (dec_res)
  );

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.device_data, out_res_r.read_data,
                       out_res_r.io_unit, out_res_r.device_address,
                       out_res_r.device_select};
  assign out_tuser  = {out_res_r.is_write, out_res_r.port_hit};

endmodule

@@ hw/rtl/bsad_port.sv @@
// Processor port registers with forwarding of a write in flight.
`timescale 1ns / 1ps

module bsad_port (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  logic                command,
  input  logic [15:0]         address,
  input  logic [7:0]          write_data,
  output bsad_pkg::bank_bits_t bank,
  output logic [7:0]          read_data
);

  logic [7:0] port_dir_r;
  logic [7:0] port_dir_nxt;
  logic [7:0] port_data_r;
  logic [7:0] port_data_nxt;
  logic       wr_dir;
  logic       wr_data;

  assign wr_dir  = command && (address == bsad_pkg::PORT_DIR_ADDR);
  assign wr_data = command && (address == bsad_pkg::PORT_DATA_ADDR);

  // Port bytes change only when the beat that writes them is retired.
  always_comb begin
    port_dir_nxt  = port_dir_r;
    port_data_nxt = port_data_r;
    if (commit && wr_dir) begin
      port_dir_nxt = write_data;
    end
    if (commit && wr_data) begin
      port_data_nxt = write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_dir_r  <= bsad_pkg::PORT_DIR_RESET;
      port_data_r <= bsad_pkg::PORT_DATA_RESET;
    end else begin
      port_dir_r  <= port_dir_nxt;
      port_data_r <= port_data_nxt;
    end
  end

  // A write to the data byte decodes with its own new banking bits.
  always_comb begin
    if (wr_data) begin
      bank = bsad_pkg::bank_bits_t'(write_data[2:0]);
    end else begin
      bank = bsad_pkg::bank_bits_t'(port_data_r[2:0]);
    end
  end

  // Read-back of the port byte selected by the low address bit.
  assign read_data = address[0] ? port_data_r : port_dir_r;

endmodule

@@ hw/rtl/bsad_decode.sv @@
// Combinational decode of one bus access into device, masked address and I/O unit.
`timescale 1ns / 1ps

module bsad_decode (
  input  logic                 command,
  input  logic [15:0]          address,
  input  logic [7:0]           write_data,
  input  logic                 rom_line,
  input  logic                 game_line,
  input  bsad_pkg::bank_bits_t bank,
  input  logic [7:0]           port_rd_data,
  output bsad_pkg::result_t    result
);

  bsad_pkg::region_t region;
  bsad_pkg::dev_t    dev;
  logic              ultimax;
  logic              port_read;

  assign region    = bsad_pkg::region_of(address[15:12]);
  assign ultimax   = rom_line && !game_line;
  assign port_read = !command && (address[15:1] == 15'd0);

  // Device selection per region from the cartridge lines and banking bits.
  always_comb begin
    unique case (region)
      bsad_pkg::REG_LO: begin
        dev = bsad_pkg::DEV_RAM;
      end
      bsad_pkg::REG_MID, bsad_pkg::REG_HIRAM: begin
        dev = ultimax ? bsad_pkg::DEV_NONE : bsad_pkg::DEV_RAM;
      end
      bsad_pkg::REG_LOCART: begin
        if (rom_line) begin
          dev = game_line ? bsad_pkg::DEV_RAM : bsad_pkg::DEV_CART_LO;
        end else begin
          dev = (bank.lo && bank.hi) ? bsad_pkg::DEV_CART_LO : bsad_pkg::DEV_RAM;
        end
      end
      bsad_pkg::REG_BASIC: begin
        if (ultimax) begin
          dev = bsad_pkg::DEV_NONE;
        end else if (!rom_line && !game_line && bank.hi) begin
          dev = bsad_pkg::DEV_CART_HI;
        end else if (bank.lo && bank.hi) begin
          dev = bsad_pkg::DEV_BASIC;
        end else begin
          dev = bsad_pkg::DEV_RAM;
        end
      end
      bsad_pkg::REG_IO: begin
        if (ultimax) begin
          dev = bsad_pkg::DEV_IO;
        end else if (!bank.lo && !bank.hi) begin
          dev = bsad_pkg::DEV_RAM;
        end else if (bank.chr) begin
          dev = bsad_pkg::DEV_IO;
        end else if (!game_line) begin
          dev = bsad_pkg::DEV_RAM;
        end else begin
          dev = bsad_pkg::DEV_CHAR;
        end
      end
      default: begin
        if (ultimax) begin
          dev = bsad_pkg::DEV_CART_HI;
        end else begin
          dev = bank.hi ? bsad_pkg::DEV_KERNAL : bsad_pkg::DEV_RAM;
        end
      end
    endcase
  end

  // Result fields; a port read blanks the bus side of the beat.
  always_comb begin
    result = '0;
    if (port_read) begin
      result.port_hit  = 1'b1;
      result.read_data = port_rd_data;
    end else begin
      result.device_select  = dev;
      result.device_address = address & bsad_pkg::mask_of(dev);
      result.io_unit        = (dev == bsad_pkg::DEV_IO) ?
                              bsad_pkg::io_unit_of(address[11:8]) : bsad_pkg::IO_VIDEO;
      result.is_write       = command;
      result.device_data    = command ? write_data : 8'h00;
    end
  end

endmodule

@@ hw/rtl/bsad_checker.sv @@
// Port-level checks for the bank-switch address decoder, bound to the top level.
`timescale 1ns / 1ps

module bsad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A port read carries no bus access.
  a_port_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[2:0] == 3'd0) && !out_tuser[1])
    else $error("port read also selected a device");

  // No device means no address.
  a_none_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == 3'd0) |-> (out_tdata[18:3] == 16'h0000))
    else $error("address driven with no device selected");

  // An I/O unit other than the first appears only with the I/O device.
  a_io_unit_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[21:19] != 3'd0) |-> (out_tdata[2:0] == 3'd6))
    else $error("I/O unit set outside the I/O device");

endmodule

bind bank_switch_address_decoder bsad_checker u_bsad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/tb_bank_switch_address_decoder.sv @@
// Self-checking testbench for the bank-switch address decoder with a bus-map scoreboard.
`timescale 1ns / 1ps

// Tracks the processor port and cartridge lines and predicts each decoded beat.
class bank_map_scoreboard;
  bit                rom_line;
  bit                game_line;
  logic [7:0]        port_dir;
  logic [7:0]        port_val;
  bsad_pkg::result_t decode_q[$];
  int                mismatches;

  function new();
    rom_line   = 1'b0;
    game_line  = 1'b0;
    port_dir   = bsad_pkg::PORT_DIR_RESET;
    port_val   = bsad_pkg::PORT_DATA_RESET;
    mismatches = 0;
  endfunction

  // Mirrors a cartridge line write.
  function void set_line(logic idx, bit val);
    if (idx == bsad_pkg::CFG_ROM_LINE) begin
      rom_line = val;
    end else begin
      game_line = val;
    end
  endfunction

  function int pending();
    return decode_q.size();
  endfunction

  // Device visible in a 4 KiB block under the current lines and port bits.
  function bsad_pkg::dev_t device_for(logic [3:0] blk);
    bit ultimax;
    bit lo;
    bit hi;
    bit chr;
    ultimax = rom_line && !game_line;
    lo      = port_val[0];
    hi      = port_val[1];
    chr     = port_val[2];
    if (blk == 4'h0) return bsad_pkg::DEV_RAM;
    if (blk < 4'h8 || blk == 4'hC) begin
      return ultimax ? bsad_pkg::DEV_NONE : bsad_pkg::DEV_RAM;
    end
    if (blk < 4'hA) begin
      if (rom_line) return game_line ? bsad_pkg::DEV_RAM : bsad_pkg::DEV_CART_LO;
      return (lo && hi) ? bsad_pkg::DEV_CART_LO : bsad_pkg::DEV_RAM;
    end
    if (blk < 4'hC) begin
      if (ultimax) return bsad_pkg::DEV_NONE;
      if (!rom_line && !game_line && hi) return bsad_pkg::DEV_CART_HI;
      if (lo && hi) return bsad_pkg::DEV_BASIC;
      return bsad_pkg::DEV_RAM;
    end
    if (blk == 4'hD) begin
      if (ultimax) return bsad_pkg::DEV_IO;
      if (!lo && !hi) return bsad_pkg::DEV_RAM;
      if (chr) return bsad_pkg::DEV_IO;
      if (!game_line) return bsad_pkg::DEV_RAM;
      return bsad_pkg::DEV_CHAR;
    end
    // Kernal blocks: the ultimax cartridge wins, otherwise HIRAM decides.
    if (ultimax) return bsad_pkg::DEV_CART_HI;
    return hi ? bsad_pkg::DEV_KERNAL : bsad_pkg::DEV_RAM;
  endfunction

  // Predicts the decoded beat of one accepted bus access.
  function void note_access(bit wr, logic [15:0] addr, logic [7:0] data);
    bsad_pkg::result_t e;
    bsad_pkg::dev_t    dev;
    int                size_bits;
    logic [3:0]        page;
    e = '0;
    if (!wr && (addr == bsad_pkg::PORT_DIR_ADDR || addr == bsad_pkg::PORT_DATA_ADDR)) begin
      e.port_hit  = 1'b1;
      e.read_data = (addr == bsad_pkg::PORT_DIR_ADDR) ? port_dir : port_val;
      decode_q.push_back(e);
      return;
    end
    // Port writes land first and still go out as bus writes.
    if (wr && addr == bsad_pkg::PORT_DIR_ADDR) port_dir = data;
    if (wr && addr == bsad_pkg::PORT_DATA_ADDR) port_val = data;
    dev = device_for(addr[15:12]);
    case (dev)
      bsad_pkg::DEV_NONE:                       size_bits = 0;
      bsad_pkg::DEV_RAM:                        size_bits = 16;
      bsad_pkg::DEV_CART_HI, bsad_pkg::DEV_CHAR: size_bits = 12;
      default:                                  size_bits = 13;
    endcase
    e.device_select  = dev;
    e.device_address = addr & 16'((32'h1 << size_bits) - 1);
    if (dev == bsad_pkg::DEV_IO) begin
      page = addr[11:8];
      if (page < 4'h4) e.io_unit = bsad_pkg::IO_VIDEO;
      else if (page < 4'h8) e.io_unit = bsad_pkg::IO_SOUND;
      else if (page < 4'hC) e.io_unit = bsad_pkg::IO_COLOR;
      else if (page == 4'hC) e.io_unit = bsad_pkg::IO_CIA1;
      else if (page == 4'hD) e.io_unit = bsad_pkg::IO_CIA2;
      else if (page == 4'hE) e.io_unit = bsad_pkg::IO_IO1;
      else e.io_unit = bsad_pkg::IO_IO2;
    end
    e.is_write    = wr;
    e.device_data = wr ? data : 8'h00;
    decode_q.push_back(e);
  endfunction

  // Compares one result beat against the oldest prediction.
  function void check_result(logic [39:0] tdata, logic [1:0] tuser);
    bsad_pkg::result_t e;
    bit                bad;
    if (decode_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: tdata=%h tuser=%b", tdata, tuser);
      return;
    end
    e   = decode_q.pop_front();
    bad = (tdata[2:0] != e.device_select) || (tdata[18:3] != e.device_address) ||
          (tdata[21:19] != e.io_unit) || (tdata[29:22] != e.read_data) ||
          (tdata[37:30] != e.device_data) || (tuser[0] != e.port_hit) ||
          (tuser[1] != e.is_write);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("decode mismatch: exp dev=%0d addr=%h io=%0d hit=%0d rd=%h wr=%0d dd=%h",
                 e.device_select, e.device_address, e.io_unit, e.port_hit, e.read_data,
                 e.is_write, e.device_data);
        $display("                 got dev=%0d addr=%h io=%0d hit=%0d rd=%h wr=%0d dd=%h",
                 tdata[2:0], tdata[18:3], tdata[21:19], tuser[0], tdata[29:22],
                 tuser[1], tdata[37:30]);
      end
    end
  endfunction
endclass

module tb_bank_switch_address_decoder;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        steady = 1'b0;

  bank_map_scoreboard sb = new();

  bank_switch_address_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 13);
  end

  // Both handshakes are sampled at the edge where they complete.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Offers one access beat and returns at the edge that takes it.
  task automatic send_access(bit wr, logic [15:0] addr, logic [7:0] data);
    if (!steady && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= wr;
    in_tdata  <= {data, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every predicted beat has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both cartridge lines on consecutive edges.
  task automatic set_lines(bit rom, bit game);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= bsad_pkg::CFG_ROM_LINE;
    cfg_wr_data <= rom;
    sb.set_line(bsad_pkg::CFG_ROM_LINE, rom);
    @(posedge clk);
    cfg_index   <= bsad_pkg::CFG_GAME_LINE;
    cfg_wr_data <= game;
    sb.set_line(bsad_pkg::CFG_GAME_LINE, game);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    bit          rom_seq [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    bit          game_seq [5] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    int          k;
    int          pick;
    bit          wr;
    logic [15:0] a;
    logic [7:0]  d;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: port read-back from reset, direction writes, every region and I/O unit.
    send_access(1'b0, bsad_pkg::PORT_DIR_ADDR, 8'h00);
    send_access(1'b0, bsad_pkg::PORT_DATA_ADDR, 8'hFF);
    send_access(1'b1, bsad_pkg::PORT_DIR_ADDR, 8'hFF);
    send_access(1'b0, bsad_pkg::PORT_DIR_ADDR, 8'h00);
    send_access(1'b0, 16'h0002, 8'h00);
    send_access(1'b0, 16'h7FFF, 8'h00);
    send_access(1'b0, 16'h8000, 8'h00);
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b0, 16'hC000, 8'h00);
    send_access(1'b0, 16'hD000, 8'h00);
    send_access(1'b0, 16'hD400, 8'h00);
    send_access(1'b0, 16'hD800, 8'h00);
    send_access(1'b0, 16'hDC00, 8'h00);
    send_access(1'b0, 16'hDD00, 8'h00);
    send_access(1'b1, 16'hDE00, 8'hA5);
    send_access(1'b0, 16'hDFFF, 8'h00);
    send_access(1'b1, 16'hFFFF, 8'hFF);
    // Kernal hidden once HIRAM drops, then everything banked out.
    send_access(1'b1, bsad_pkg::PORT_DATA_ADDR, 8'h35);
    send_access(1'b0, 16'hE000, 8'h00);
    send_access(1'b1, bsad_pkg::PORT_DATA_ADDR, 8'h00);
    send_access(1'b0, 16'hD000, 8'h00);
    send_access(1'b0, bsad_pkg::PORT_DATA_ADDR, 8'h00);
    send_access(1'b1, bsad_pkg::PORT_DIR_ADDR, 8'h00);
    send_access(1'b1, bsad_pkg::PORT_DATA_ADDR, 8'h33);
    send_access(1'b0, 16'hD123, 8'h00);

    // Random accesses under each cartridge line setting.
    for (int phase = 0; phase < 5; phase++) begin
      drain_results();
      set_lines(rom_seq[phase], game_seq[phase]);
      for (k = 0; k < 185; k++) begin
        if (phase == 1 && k == 40) steady <= 1'b1;
        if (phase == 1 && k == 160) steady <= 1'b0;
        if (phase == 3 && k == 90) drain_results();
        pick = $urandom_range(99);
        wr   = 1'($urandom_range(1));
        d    = 8'($urandom_range(255));
        a    = 16'($urandom_range(65535));
        if (pick < 15) begin
          wr = 1'b1;
          a  = bsad_pkg::PORT_DATA_ADDR;
        end else if (pick < 22) begin
          a = 16'($urandom_range(1));
        end else if (pick < 42) begin
          a = {4'hD, 12'($urandom_range(4095))};
        end else if (pick < 55) begin
          a = {4'($urandom_range(15, 8)), 12'($urandom_range(4095))};
        end
        send_access(wr, a, d);
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
